/* src/wsd_pkg.sv */
// Package for the wheel slip detector: widths, constants, payload types and helpers.
package wsd_pkg;

	// Fixed-point format of all rates, speeds and accelerations.
	localparam int FRAC_BITS = 16;
	localparam int VALUE_BITS = 24;

	// Fixed field widths.
	localparam int LIMIT_W = 23;
	localparam int COUNT_W = 8;
	localparam int US_W = 16;
	localparam int CFG_IDX_W = 4;

	// Magnitudes of differences need one bit more than a value.
	localparam int MAG_W = VALUE_BITS + 1;
	localparam int CMP_W = (MAG_W > LIMIT_W) ? MAG_W : LIMIT_W;

	// Integration divider: 1000000 = 2^6 * 15625. The product is shifted right by six,
	// then divided by 15625 through a reciprocal multiply and one correction step.
	localparam int PROD_W = VALUE_BITS + US_W;
	localparam int PRE_SHIFT = 6;
	localparam int DIV_K = PROD_W - PRE_SHIFT;
	localparam longint DIV_ODD = 15625;
	localparam int DIV_ODD_LOG = 13;
	localparam int QUO_W = DIV_K - DIV_ODD_LOG;
	localparam longint RECIP = (longint'(1) << DIV_K) / DIV_ODD;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = DIV_K;
	localparam int MUL_B_W = (QUO_W > US_W) ? QUO_W : US_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Saturation bounds of the speed estimate.
	localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// Clamp a constant to the limit register range.
	function automatic logic [LIMIT_W-1:0] clamp_limit(input longint v);
		longint lmax;
		lmax = (longint'(1) << LIMIT_W) - 1;
		return (v > lmax) ? LIMIT_W'(lmax) : LIMIT_W'(v);
	endfunction

	// Register reset values, derived from the fraction width.
	localparam longint ONE_FIXED = longint'(1) << FRAC_BITS;
	localparam logic [LIMIT_W-1:0] RST_X_ACC_DIFF = clamp_limit(ONE_FIXED);
	localparam logic [LIMIT_W-1:0] RST_X_ACC_WHEEL = clamp_limit(ONE_FIXED);
	localparam logic [LIMIT_W-1:0] RST_GYRO_YAW = clamp_limit(ONE_FIXED);
	localparam logic [LIMIT_W-1:0] RST_YAW_DIFF = clamp_limit(6 * ONE_FIXED);
	localparam logic [LIMIT_W-1:0] RST_YAW_WHEEL = clamp_limit(12 * ONE_FIXED);
	localparam logic [LIMIT_W-1:0] RST_SPEED_DIFF = clamp_limit((ONE_FIXED + 500) / 1000);
	localparam logic [LIMIT_W-1:0] RST_LOW_SPEED = clamp_limit((ONE_FIXED * 5 + 50) / 100);
	localparam logic [COUNT_W-1:0] RST_DEBOUNCE = COUNT_W'(50);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ACC_DIFF = 4'd0,
		REG_X_ACC_WHEEL = 4'd1,
		REG_GYRO_YAW = 4'd2,
		REG_YAW_DIFF = 4'd3,
		REG_YAW_WHEEL = 4'd4,
		REG_SPEED_DIFF = 4'd5,
		REG_LOW_SPEED = 4'd6,
		REG_DEBOUNCE = 4'd7
	} wsd_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PROD,
		S_RECIP,
		S_BACK,
		S_CORR,
		S_EST,
		S_DONE
	} wsd_state_t;

	// Configuration register set.
	typedef struct packed {
		logic [LIMIT_W-1:0] x_acc_diff_limit;
		logic [LIMIT_W-1:0] x_acc_wheel_limit;
		logic [LIMIT_W-1:0] gyro_yaw_limit;
		logic [LIMIT_W-1:0] yaw_diff_limit;
		logic [LIMIT_W-1:0] yaw_wheel_limit;
		logic [LIMIT_W-1:0] speed_diff_limit;
		logic [LIMIT_W-1:0] low_speed_limit;
		logic [COUNT_W-1:0] debounce_ticks;
	} wsd_cfg_t;

	// One control tick.
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] wheel_accel;
		logic signed [VALUE_BITS-1:0] imu_accel;
		logic signed [VALUE_BITS-1:0] wheel_yaw_rate;
		logic signed [VALUE_BITS-1:0] gyro_yaw_rate;
		logic signed [VALUE_BITS-1:0] wheel_speed;
		logic [US_W-1:0] elapsed_us;
	} wsd_sample_t;

	// One result.
	typedef struct packed {
		logic slipping;
		logic drive_enable;
		logic forward_slip;
		logic yaw_slip;
		logic signed [VALUE_BITS-1:0] speed_estimate;
		logic [COUNT_W-1:0] debounce_count;
	} wsd_result_t;

	// Sign-extend a value to the difference width.
	function automatic logic signed [MAG_W-1:0] widen(input logic signed [VALUE_BITS-1:0] v);
		return MAG_W'(v);
	endfunction

	// Magnitude of a difference-width value, extended to the compare width.
	function automatic logic [CMP_W-1:0] abs_mag(input logic signed [MAG_W-1:0] v);
		logic [MAG_W-1:0] m;
		m = v[MAG_W-1] ? -v : v;
		return CMP_W'(m);
	endfunction

endpackage

/* src/wheel_slip_detector.sv */
// Top level of the wheel slip detector: sequencer, slip state and result register.
// Each sample passes through the shared multiplier three times (product, reciprocal,
// back-multiply), then the correction, estimate update and finish steps; the next sample
// is taken only once the sequencer has returned to idle.
// A waiting result does not block the next sample; only the finish step waits for it.
// Reset (arst_n low, asynchronous) clears slip state, flags, estimate and counter and loads
// the default thresholds.
module wheel_slip_detector (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  wsd_pkg::wsd_sample_t            sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output wsd_pkg::wsd_result_t            result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wsd_pkg::LIMIT_W-1:0]     cfg_data
);

	wsd_pkg::wsd_cfg_t cfg;
	wsd_pkg::wsd_state_t state_q, state_d;
	wsd_pkg::wsd_sample_t smp_q;
	wsd_pkg::wsd_result_t res_q;
	logic res_valid_q;

	logic [wsd_pkg::MUL_A_W-1:0] mul_a;
	logic [wsd_pkg::MUL_B_W-1:0] mul_b;
	logic [wsd_pkg::MUL_P_W-1:0] mul_p;

	logic [wsd_pkg::DIV_K-1:0] x_q;
	logic [wsd_pkg::QUO_W-1:0] q0_q;
	logic [wsd_pkg::QUO_W-1:0] quo_q;
	logic fwd_set_q, yaw_set_q, yaw_clr_q, low_q;

	logic slip_q, fwd_q, yaw_q, started_q;
	logic signed [wsd_pkg::VALUE_BITS-1:0] est_q;
	logic [wsd_pkg::COUNT_W-1:0] cnt_q;

	logic sample_fire, done_fire;
	logic [wsd_pkg::CMP_W-1:0] mag_wa, mag_ia, mag_wy, mag_gy, mag_ws;
	logic [wsd_pkg::CMP_W-1:0] mag_acc_gap, mag_yaw_gap, mag_spd_gap;
	logic fwd_set, yaw_set, yaw_clr, low_spd, spd_close;
	logic [wsd_pkg::DIV_K-1:0] rem;
	logic [wsd_pkg::QUO_W-1:0] quo_fix;
	logic [wsd_pkg::MAG_W-1:0] quo_ext;
	logic signed [wsd_pkg::MAG_W-1:0] quo_sgn, est_sum;
	logic signed [wsd_pkg::VALUE_BITS-1:0] est_sat, est_d;
	logic started_d;
	logic fwd_d, yaw_d, slip_d;
	logic [wsd_pkg::COUNT_W-1:0] cnt_inc, cnt_d;

	// Configuration registers.
	wsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Shared multiplier.
	wsd_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	assign sample_ready = (state_q == wsd_pkg::S_IDLE);
	assign sample_fire = sample_valid && sample_ready;
	assign done_fire = (state_q == wsd_pkg::S_DONE) && (!res_valid_q || result_ready);
	assign result_valid = res_valid_q;
	assign result = res_q;

	// Magnitudes and gaps of the held sample.
	always_comb begin
		mag_wa = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.wheel_accel));
		mag_ia = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.imu_accel));
		mag_wy = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.wheel_yaw_rate));
		mag_gy = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.gyro_yaw_rate));
		mag_ws = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.wheel_speed));
		mag_acc_gap = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.wheel_accel)
			- wsd_pkg::widen(smp_q.imu_accel));
		mag_yaw_gap = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.wheel_yaw_rate)
			- wsd_pkg::widen(smp_q.gyro_yaw_rate));
		mag_spd_gap = wsd_pkg::abs_mag(wsd_pkg::widen(smp_q.wheel_speed)
			- wsd_pkg::widen(est_q));
	end

	// Threshold tests for setting and clearing the raw flags.
	always_comb begin
		fwd_set = (mag_acc_gap > wsd_pkg::CMP_W'(cfg.x_acc_diff_limit)) && (mag_wa > mag_ia)
			&& (mag_wa > wsd_pkg::CMP_W'(cfg.x_acc_wheel_limit))
			&& (mag_gy < wsd_pkg::CMP_W'(cfg.gyro_yaw_limit));
		yaw_set = (mag_yaw_gap > wsd_pkg::CMP_W'(cfg.yaw_diff_limit)) && (mag_wy > mag_gy)
			&& (mag_wy > wsd_pkg::CMP_W'(cfg.yaw_wheel_limit));
		yaw_clr = mag_yaw_gap < wsd_pkg::CMP_W'(cfg.yaw_diff_limit);
		low_spd = mag_ws < wsd_pkg::CMP_W'(cfg.low_speed_limit);
		spd_close = mag_spd_gap < wsd_pkg::CMP_W'(cfg.speed_diff_limit);
	end

	// Multiplier operands for each pass of the divider.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			wsd_pkg::S_PROD: begin
				mul_a = wsd_pkg::MUL_A_W'(mag_ia);
				mul_b = wsd_pkg::MUL_B_W'(smp_q.elapsed_us);
			end
			wsd_pkg::S_RECIP: begin
				mul_a = mul_p[wsd_pkg::PRE_SHIFT +: wsd_pkg::DIV_K];
				mul_b = wsd_pkg::MUL_B_W'(wsd_pkg::RECIP);
			end
			wsd_pkg::S_BACK: begin
				mul_a = wsd_pkg::MUL_A_W'(mul_p[wsd_pkg::DIV_K +: wsd_pkg::QUO_W]);
				mul_b = wsd_pkg::MUL_B_W'(wsd_pkg::DIV_ODD);
			end
			default: begin
			end
		endcase
	end

	// Quotient correction and the saturated estimate update.
	always_comb begin
		rem = x_q - mul_p[wsd_pkg::DIV_K-1:0];
		quo_fix = q0_q + wsd_pkg::QUO_W'(rem >= wsd_pkg::DIV_K'(wsd_pkg::DIV_ODD));
		quo_ext = wsd_pkg::MAG_W'(quo_q);
		quo_sgn = smp_q.imu_accel[wsd_pkg::VALUE_BITS-1] ? -quo_ext : quo_ext;
		est_sum = wsd_pkg::widen(est_q) + quo_sgn;
		if (est_sum[wsd_pkg::MAG_W-1] != est_sum[wsd_pkg::MAG_W-2]) begin
			est_sat = est_sum[wsd_pkg::MAG_W-1] ? wsd_pkg::VALUE_MIN : wsd_pkg::VALUE_MAX;
		end else begin
			est_sat = est_sum[wsd_pkg::VALUE_BITS-1:0];
		end
		if (!slip_q) begin
			est_d = smp_q.wheel_speed;
			started_d = 1'b0;
		end else if (!started_q) begin
			est_d = smp_q.wheel_speed;
			started_d = 1'b1;
		end else begin
			est_d = est_sat;
			started_d = 1'b1;
		end
	end

	// Flag update and debounce counter.
	always_comb begin
		fwd_d = (fwd_q || fwd_set_q) && !(slip_q && (spd_close || low_q));
		yaw_d = (yaw_q || yaw_set_q) && !(slip_q && yaw_clr_q);
		cnt_inc = (cnt_q != '1) ? cnt_q + wsd_pkg::COUNT_W'(1) : cnt_q;
		slip_d = slip_q;
		cnt_d = cnt_q;
		if (fwd_d || yaw_d) begin
			cnt_d = cnt_inc;
			if (cnt_inc >= cfg.debounce_ticks) begin
				slip_d = 1'b1;
				cnt_d = cfg.debounce_ticks;
			end
		end else if (cnt_q != '0) begin
			cnt_d = cnt_q - wsd_pkg::COUNT_W'(1);
		end else begin
			slip_d = 1'b0;
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wsd_pkg::S_IDLE: if (sample_fire) state_d = wsd_pkg::S_PROD;
			wsd_pkg::S_PROD: state_d = wsd_pkg::S_RECIP;
			wsd_pkg::S_RECIP: state_d = wsd_pkg::S_BACK;
			wsd_pkg::S_BACK: state_d = wsd_pkg::S_CORR;
			wsd_pkg::S_CORR: state_d = wsd_pkg::S_EST;
			wsd_pkg::S_EST: state_d = wsd_pkg::S_DONE;
			wsd_pkg::S_DONE: if (done_fire) state_d = wsd_pkg::S_IDLE;
			default: state_d = wsd_pkg::S_IDLE;
		endcase
	end

	// Working registers of one tick.
	always_ff @(posedge clk) begin
		if (sample_fire) begin
			smp_q <= sample;
		end
		if (state_q == wsd_pkg::S_PROD) begin
			fwd_set_q <= fwd_set;
			yaw_set_q <= yaw_set;
			yaw_clr_q <= yaw_clr;
			low_q <= low_spd;
		end
		if (state_q == wsd_pkg::S_RECIP) begin
			x_q <= mul_p[wsd_pkg::PRE_SHIFT +: wsd_pkg::DIV_K];
		end
		if (state_q == wsd_pkg::S_BACK) begin
			q0_q <= mul_p[wsd_pkg::DIV_K +: wsd_pkg::QUO_W];
		end
		if (state_q == wsd_pkg::S_CORR) begin
			quo_q <= quo_fix;
		end
		if (done_fire) begin
			res_q.slipping <= slip_d;
			res_q.drive_enable <= !slip_d;
			res_q.forward_slip <= fwd_d;
			res_q.yaw_slip <= yaw_d;
			res_q.speed_estimate <= est_q;
			res_q.debounce_count <= cnt_d;
		end
	end

	// Persistent slip state and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slip_q <= 1'b0;
			fwd_q <= 1'b0;
			yaw_q <= 1'b0;
			started_q <= 1'b0;
			est_q <= '0;
			cnt_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == wsd_pkg::S_EST) begin
				est_q <= est_d;
				started_q <= started_d;
			end
			if (done_fire) begin
				slip_q <= slip_d;
				fwd_q <= fwd_d;
				yaw_q <= yaw_d;
				cnt_q <= cnt_d;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// A new result appears only from the finish step.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == wsd_pkg::S_DONE)
		else $error("result became valid outside the finish step");

	// Drive enable is always the inverse of the slip state.
	a_drive_enable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.drive_enable != result.slipping)
		else $error("drive enable does not match slip state");

	// The slip state ends only once the debounce counter has run down.
	a_slip_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(slip_q) |-> cnt_q == '0)
		else $error("slip state cleared with a nonzero counter");

	// Outside slip the estimate follows the wheel speed.
	a_est_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wsd_pkg::S_DONE && !slip_q) |-> est_q == smp_q.wheel_speed)
		else $error("estimate does not track wheel speed outside slip");

endmodule

/* src/wsd_cfg.sv */
// Configuration register file of the wheel slip detector.
module wsd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wsd_pkg::LIMIT_W-1:0]     cfg_data,
	output wsd_pkg::wsd_cfg_t               cfg
);

	wsd_pkg::wsd_cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_acc_diff_limit <= wsd_pkg::RST_X_ACC_DIFF;
			cfg_q.x_acc_wheel_limit <= wsd_pkg::RST_X_ACC_WHEEL;
			cfg_q.gyro_yaw_limit <= wsd_pkg::RST_GYRO_YAW;
			cfg_q.yaw_diff_limit <= wsd_pkg::RST_YAW_DIFF;
			cfg_q.yaw_wheel_limit <= wsd_pkg::RST_YAW_WHEEL;
			cfg_q.speed_diff_limit <= wsd_pkg::RST_SPEED_DIFF;
			cfg_q.low_speed_limit <= wsd_pkg::RST_LOW_SPEED;
			cfg_q.debounce_ticks <= wsd_pkg::RST_DEBOUNCE;
		end else if (cfg_valid) begin
			case (wsd_pkg::wsd_reg_t'(cfg_index))
				wsd_pkg::REG_X_ACC_DIFF: cfg_q.x_acc_diff_limit <= cfg_data;
				wsd_pkg::REG_X_ACC_WHEEL: cfg_q.x_acc_wheel_limit <= cfg_data;
				wsd_pkg::REG_GYRO_YAW: cfg_q.gyro_yaw_limit <= cfg_data;
				wsd_pkg::REG_YAW_DIFF: cfg_q.yaw_diff_limit <= cfg_data;
				wsd_pkg::REG_YAW_WHEEL: cfg_q.yaw_wheel_limit <= cfg_data;
				wsd_pkg::REG_SPEED_DIFF: cfg_q.speed_diff_limit <= cfg_data;
				wsd_pkg::REG_LOW_SPEED: cfg_q.low_speed_limit <= cfg_data;
				wsd_pkg::REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_data[wsd_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

/* src/wsd_mul.sv */
// Shared unsigned multiplier with a registered product.
module wsd_mul (
	input  logic                          clk,
	input  logic [wsd_pkg::MUL_A_W-1:0]   a,
	input  logic [wsd_pkg::MUL_B_W-1:0]   b,
	output logic [wsd_pkg::MUL_P_W-1:0]   prod
);

	logic [wsd_pkg::MUL_P_W-1:0] prod_q;

	// One multiply per cycle, result available the next cycle.
	always_ff @(posedge clk) begin
		prod_q <= wsd_pkg::MUL_P_W'(a) * wsd_pkg::MUL_P_W'(b);
	end

	assign prod = prod_q;

endmodule

/* tb/slip_tb_pkg.sv */
// Scoreboard for the wheel slip detector: tick predictor and queue of expected results.
package slip_tb_pkg;
	import wsd_pkg::*;

	localparam longint US_PER_SECOND = 1000000;
	localparam longint FIELD_MAX = longint'(VALUE_MAX);
	localparam longint FIELD_MIN = longint'(VALUE_MIN);
	localparam int COUNT_MAX = (1 << COUNT_W) - 1;

	// Saturate to the signed value range of a rate or speed.
	function automatic longint clamp_value(input longint v);
		if (v > FIELD_MAX) begin
			return FIELD_MAX;
		end
		if (v < FIELD_MIN) begin
			return FIELD_MIN;
		end
		return v;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	class slip_scoreboard;
		wsd_cfg_t limits;
		bit slip_state;
		bit fwd_flag;
		bit yaw_flag;
		bit est_started;
		longint estimate;
		int unsigned tick_count;
		wsd_result_t expected_q[$];
		int errors;

		function new();
			limits.x_acc_diff_limit = RST_X_ACC_DIFF;
			limits.x_acc_wheel_limit = RST_X_ACC_WHEEL;
			limits.gyro_yaw_limit = RST_GYRO_YAW;
			limits.yaw_diff_limit = RST_YAW_DIFF;
			limits.yaw_wheel_limit = RST_YAW_WHEEL;
			limits.speed_diff_limit = RST_SPEED_DIFF;
			limits.low_speed_limit = RST_LOW_SPEED;
			limits.debounce_ticks = RST_DEBOUNCE;
			slip_state = 1'b0;
			fwd_flag = 1'b0;
			yaw_flag = 1'b0;
			est_started = 1'b0;
			estimate = 0;
			tick_count = 0;
			errors = 0;
		endfunction

		// Mirror a register write; unknown indexes leave everything as it is.
		function void apply_config(input logic [CFG_IDX_W-1:0] reg_index,
				input logic [LIMIT_W-1:0] value);
			case (reg_index)
				REG_X_ACC_DIFF: limits.x_acc_diff_limit = value;
				REG_X_ACC_WHEEL: limits.x_acc_wheel_limit = value;
				REG_GYRO_YAW: limits.gyro_yaw_limit = value;
				REG_YAW_DIFF: limits.yaw_diff_limit = value;
				REG_YAW_WHEEL: limits.yaw_wheel_limit = value;
				REG_SPEED_DIFF: limits.speed_diff_limit = value;
				REG_LOW_SPEED: limits.low_speed_limit = value;
				REG_DEBOUNCE: limits.debounce_ticks = value[COUNT_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the detector state by one accepted tick and queue the result it causes.
		function void note_sample(input wsd_sample_t s);
			longint wa;
			longint ia;
			longint wy;
			longint gy;
			longint ws;
			longint us;
			bit was_slipping;
			wsd_result_t r;
			wa = longint'($signed(s.wheel_accel));
			ia = longint'($signed(s.imu_accel));
			wy = longint'($signed(s.wheel_yaw_rate));
			gy = longint'($signed(s.gyro_yaw_rate));
			ws = longint'($signed(s.wheel_speed));
			us = longint'(s.elapsed_us);
			was_slipping = slip_state;

			// The estimate follows the wheels until slip; then it integrates the IMU.
			if (!was_slipping) begin
				estimate = ws;
				est_started = 1'b0;
			end else if (!est_started) begin
				estimate = ws;
				est_started = 1'b1;
			end else begin
				estimate = clamp_value(estimate + (ia * us) / US_PER_SECOND);
			end

			// Set tests; the flags are sticky.
			if (magnitude(wa - ia) > longint'(limits.x_acc_diff_limit) &&
					magnitude(wa) > magnitude(ia) &&
					magnitude(wa) > longint'(limits.x_acc_wheel_limit) &&
					magnitude(gy) < longint'(limits.gyro_yaw_limit)) begin
				fwd_flag = 1'b1;
			end
			if (magnitude(wy - gy) > longint'(limits.yaw_diff_limit) &&
					magnitude(wy) > magnitude(gy) &&
					magnitude(wy) > longint'(limits.yaw_wheel_limit)) begin
				yaw_flag = 1'b1;
			end

			// Clear tests only run while the previous tick was slipping.
			if (was_slipping) begin
				if (magnitude(ws - estimate) < longint'(limits.speed_diff_limit) ||
						magnitude(ws) < longint'(limits.low_speed_limit)) begin
					fwd_flag = 1'b0;
				end
				if (magnitude(wy - gy) < longint'(limits.yaw_diff_limit)) begin
					yaw_flag = 1'b0;
				end
			end

			// Debounce counter.
			if (fwd_flag || yaw_flag) begin
				if (tick_count < COUNT_MAX) begin
					tick_count++;
				end
				if (tick_count >= 32'(limits.debounce_ticks)) begin
					slip_state = 1'b1;
					tick_count = 32'(limits.debounce_ticks);
				end
			end else if (tick_count > 0) begin
				tick_count--;
			end else begin
				slip_state = 1'b0;
			end

			r.slipping = slip_state;
			r.drive_enable = !slip_state;
			r.forward_slip = fwd_flag;
			r.yaw_slip = yaw_flag;
			r.speed_estimate = VALUE_BITS'(estimate);
			r.debounce_count = COUNT_W'(tick_count);
			expected_q.push_back(r);
		endfunction

		function void compare_field(input string name, input logic signed [63:0] want,
				input logic signed [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Match a result transaction against the oldest expectation.
		function void check_result(input wsd_result_t got);
			wsd_result_t want;
			if (expected_q.size() == 0) begin
				$error("result transaction with no sample outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("slipping", 64'(want.slipping), 64'(got.slipping));
			compare_field("drive_enable", 64'(want.drive_enable), 64'(got.drive_enable));
			compare_field("forward_slip", 64'(want.forward_slip), 64'(got.forward_slip));
			compare_field("yaw_slip", 64'(want.yaw_slip), 64'(got.yaw_slip));
			compare_field("speed_estimate", 64'($signed(want.speed_estimate)),
				64'($signed(got.speed_estimate)));
			compare_field("debounce_count", 64'(want.debounce_count),
				64'(got.debounce_count));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

/* tb/tb.sv */
// Testbench top for the wheel slip detector: clock, reset, drivers, checker and stimulus.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wsd_pkg::*;
	import slip_tb_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 131;
	localparam int SPIN_BUILDUP = 140;
	localparam int DRAIN_CYCLES = 8;
	localparam int TAIL_CYCLES = 20;
	localparam int FIRST_FREE_INDEX = int'(REG_DEBOUNCE) + 1;
	localparam int LAST_INDEX = (1 << CFG_IDX_W) - 1;
	localparam int US_TOP = (1 << US_W) - 1;
	localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;

	typedef enum int {
		TICK_SPIN,
		TICK_SKID,
		TICK_GRIP,
		TICK_NOISE
	} tick_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	wsd_sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	wsd_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LIMIT_W-1:0] cfg_data = '0;

	slip_scoreboard sb = new();
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold = 0;
	int idle_cycles = 0;

	wheel_slip_detector uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int pause_len();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 65) begin
			return 0;
		end
		if (roll < 93) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Uniform signed value within +/- 2^(bits-1).
	function automatic longint spread(input int bits);
		return longint'($urandom_range((1 << bits) - 1, 0)) - (longint'(1) << (bits - 1));
	endfunction

	function automatic wsd_sample_t make_tick(input longint wa, input longint ia,
			input longint wy, input longint gy, input longint ws, input int us);
		wsd_sample_t t;
		t.wheel_accel = VALUE_BITS'(wa);
		t.imu_accel = VALUE_BITS'(ia);
		t.wheel_yaw_rate = VALUE_BITS'(wy);
		t.gyro_yaw_rate = VALUE_BITS'(gy);
		t.wheel_speed = VALUE_BITS'(ws);
		t.elapsed_us = US_W'(us);
		return t;
	endfunction

	// Shaped ticks: spinning wheel, yaw skid, regained grip, or plain noise.
	function automatic wsd_sample_t draw_tick(input tick_kind_t kind);
		longint gy;
		longint ws;
		int us;
		us = ($urandom_range(9, 0) == 0) ? int'($urandom_range(US_TOP, 0)) :
			int'($urandom_range(5000, 200));
		case (kind)
			TICK_SPIN: begin
				gy = spread(16);
				return make_tick(spread($urandom_range(24, 20)), spread(16), gy + spread(17),
					gy, spread(22), us);
			end
			TICK_SKID: begin
				gy = spread(18);
				return make_tick(spread(15), spread(15), spread($urandom_range(24, 21)), gy,
					spread(22), us);
			end
			TICK_GRIP: begin
				// Wheel speed near the current estimate, near zero, or anywhere.
				gy = spread(17);
				case ($urandom_range(2, 0))
					0: ws = clamp_value(sb.estimate + spread(8));
					1: ws = spread(12);
					default: ws = spread(20);
				endcase
				return make_tick(spread(15), spread(15), gy + spread(17), gy, ws, us);
			end
			default: begin
				return make_tick(spread(24), spread(24), spread(24), spread(24), spread(24),
					$urandom_range(US_TOP, 0));
			end
		endcase
	endfunction

	// One register write transaction, after which the channel goes quiet.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
			input logic [LIMIT_W-1:0] value);
		cfg_index <= reg_index;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_config(reg_index, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One sample transaction followed by an optional sender gap.
	task automatic push_tick(input wsd_sample_t s);
		int gap;
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		sb.note_sample(s);
		gap = tx_steady ? 0 : pause_len();
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic settle();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result side back-pressure.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			result_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			result_ready <= 1'b1;
			if (!rx_steady && $urandom_range(3, 0) == 0) begin
				rx_hold <= pause_len();
			end
		end
	end

	// Check every result transaction.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			sb.check_result(result);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [LIMIT_W-1:0] base_v [7];
		logic [LIMIT_W-1:0] lim_v;
		logic [COUNT_W-1:0] deb;
		tick_kind_t kind;
		int run_left;
		int cap;
		int roll;

		base_v = '{RST_X_ACC_DIFF, RST_X_ACC_WHEEL, RST_GYRO_YAW, RST_YAW_DIFF,
			RST_YAW_WHEEL, RST_SPEED_DIFF, RST_LOW_SPEED};
		kind = TICK_GRIP;
		run_left = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes at the default thresholds.
		push_tick(make_tick(0, 0, 0, 0, 0, 0));
		push_tick(make_tick(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, US_TOP));
		push_tick(make_tick(FIELD_MIN, FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN, US_TOP));
		// Forward slip just past each of its thresholds.
		push_tick(make_tick(longint'(RST_X_ACC_WHEEL) + 1, 0, 0, longint'(RST_GYRO_YAW) - 1,
			0, 1000));

		// Zero debounce, written with junk in the upper data bits, plus an unused index.
		settle();
		write_reg(REG_DEBOUNCE, LIMIT_W'(32'h7FFF00));
		write_reg(CFG_IDX_W'(LAST_INDEX), LIMIT_TOP);
		push_tick(make_tick(0, 0, 0, 0, 0, 1000));
		// Estimate loads the wheel speed, then saturates low.
		push_tick(make_tick(0, FIELD_MIN, FIELD_MAX, 0, FIELD_MIN, US_TOP));
		push_tick(make_tick(0, FIELD_MIN, FIELD_MAX, 0, FIELD_MIN, US_TOP));
		// Both flags cleared: counter at zero drops the slip state.
		push_tick(make_tick(0, 0, 0, 0, 0, US_TOP));
		// Re-enter slip and saturate high.
		push_tick(make_tick(0, 0, FIELD_MAX, 0, FIELD_MAX, 1000));
		push_tick(make_tick(0, FIELD_MAX, FIELD_MAX, 0, FIELD_MAX, US_TOP));
		push_tick(make_tick(0, FIELD_MAX, FIELD_MAX, 0, FIELD_MAX, US_TOP));
		// Negative increments truncate toward zero.
		push_tick(make_tick(0, -20, FIELD_MAX, 0, FIELD_MAX, US_TOP));
		push_tick(make_tick(0, -1, FIELD_MAX, 0, FIELD_MAX, 1));
		// Forward flag set and cleared by low wheel speed in the same tick.
		push_tick(make_tick(FIELD_MIN, 0, 0, 0, longint'(RST_LOW_SPEED) - 1, 1000));
		// Estimate gap one below the speed limit ends forward slip.
		push_tick(make_tick(0, 0, FIELD_MAX, 0, 5000, 1000));
		push_tick(make_tick(FIELD_MIN, 0, FIELD_MAX, 0, 5000, 1000));
		push_tick(make_tick(FIELD_MIN, 0, FIELD_MAX, 0,
			5000 + longint'(RST_SPEED_DIFF) - 1, 1000));

		// Random phases, each with its own threshold set and idling pattern.
		for (int p = 0; p < PHASES; p++) begin
			settle();
			tx_steady = (p % 3 == 0);
			rx_steady = (p % 3 == 1);

			// Threshold registers: near defaults, all zero, all ones, or anything.
			for (int k = REG_X_ACC_DIFF; k <= REG_LOW_SPEED; k++) begin
				if (p == 3) begin
					lim_v = '0;
				end else if (p == 4) begin
					lim_v = LIMIT_TOP;
				end else if (p >= 6) begin
					lim_v = LIMIT_W'($urandom);
				end else begin
					lim_v = LIMIT_W'($urandom_range(2 * int'(base_v[k]),
						int'(base_v[k]) / 2));
				end
				write_reg(CFG_IDX_W'(k), lim_v);
			end

			// Phase 1 counts toward a high debounce; phase 2 lowers it below the count.
			case (p)
				0: deb = COUNT_W'($urandom_range(8, 1));
				1: deb = COUNT_W'(COUNT_MAX);
				2: deb = COUNT_W'(4);
				3: deb = COUNT_W'(1);
				4: deb = COUNT_W'(2);
				5: deb = COUNT_W'(0);
				default: begin
					deb = ($urandom_range(9, 0) < 7) ? COUNT_W'($urandom_range(12, 1)) :
						COUNT_W'($urandom_range(COUNT_MAX, 0));
				end
			endcase
			write_reg(REG_DEBOUNCE, {(LIMIT_W - COUNT_W)'($urandom), deb});
			write_reg(CFG_IDX_W'($urandom_range(LAST_INDEX, FIRST_FREE_INDEX)),
				LIMIT_W'($urandom));

			cap = (int'(deb) + 6 > 40) ? 40 : int'(deb) + 6;
			run_left = 0;
			for (int i = 0; i < ((p == 1) ? SPIN_BUILDUP : TICKS_PER_PHASE); i++) begin
				if (run_left == 0) begin
					roll = $urandom_range(99, 0);
					kind = (roll < 35) ? TICK_SPIN : (roll < 55) ? TICK_SKID :
						(roll < 85) ? TICK_GRIP : TICK_NOISE;
					run_left = (kind == TICK_NOISE) ? $urandom_range(6, 1) :
						$urandom_range(cap, 1);
				end
				run_left--;
				push_tick(draw_tick((p == 1) ? TICK_SPIN : kind));
				if ($urandom_range(99, 0) == 0) begin
					settle();
				end
			end
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
